/* rtl/core/slbe_pkg.sv */
// ----------------------------------------------------------------------------
// slbe_pkg
// Shared types and constants of the scanline line buffer engine.
// ----------------------------------------------------------------------------
package slbe_pkg;

  localparam int LINE_CELLS_DEF = 160;
  localparam int CELL_W         = 5;
  localparam int POS_W          = 8;
  localparam int BANKS          = 4;
  localparam int BANK_AW_MAX    = 6;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_OBJECT  = 2'd1,
    CMD_GRAPHIC = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  // Readout formats.
  localparam logic [1:0] RM_WIDE   = 2'd0;
  localparam logic [1:0] RM_NONE   = 2'd1;
  localparam logic [1:0] RM_HIRES2 = 2'd2;
  localparam logic [1:0] RM_HIRES3 = 2'd3;

  // Register indexes on the configuration port.
  localparam logic REG_KANGAROO  = 1'b0;
  localparam logic REG_READ_MODE = 1'b1;

  // Write request for one cell bank.
  typedef struct packed {
    logic                   en;
    logic [BANK_AW_MAX-1:0] addr;
    logic [CELL_W-1:0]      data;
  } bank_wr_t;

endpackage

/* rtl/core/slbe_ram.sv */
// ----------------------------------------------------------------------------
// slbe_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module slbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/slbe_write.sv */
// ----------------------------------------------------------------------------
// slbe_write
// Turns one graphic byte into per-bank cell writes and the next position.
// ----------------------------------------------------------------------------
module slbe_write
  import slbe_pkg::*;
#(
  parameter int LINE_CELLS = LINE_CELLS_DEF
) (
  input  logic                   go,
  input  logic [POS_W-1:0]       position,
  input  logic [2:0]             palette,
  input  logic                   wide,
  input  logic                   kangaroo,
  input  logic [7:0]             graphic_byte,
  input  logic [15:0]            source_address,
  input  logic                   holey_eight,
  input  logic                   holey_sixteen,
  output bank_wr_t [BANKS-1:0]   bank_wr,
  output logic [POS_W-1:0]       position_next
);

  localparam logic [POS_W:0] LINE_LIMIT = (POS_W+1)'(LINE_CELLS);

  logic       holey;
  logic [7:0] data;

  // Cell nibble of the j-th cell of the byte, in write order.
  function automatic logic [3:0] slot_nib(input logic [7:0] d, input logic w,
                                          input logic [1:0] j);
    logic [3:0] n;
    n = 4'd0;
    if (w) begin
      case (j)
        2'd0:    n = {d[3:2], d[7:6]};
        2'd1:    n = {d[1:0], d[5:4]};
        default: n = 4'd0;
      endcase
    end else begin
      case (j)
        2'd0:    n = {2'b00, d[7:6]};
        2'd1:    n = {2'b00, d[5:4]};
        2'd2:    n = {2'b00, d[3:2]};
        default: n = {2'b00, d[1:0]};
      endcase
    end
    return n;
  endfunction

  assign holey = source_address[15] &&
                 ((holey_sixteen && source_address[12]) ||
                  (holey_eight && source_address[11]));
  assign data  = holey ? 8'd0 : graphic_byte;

  assign position_next = position + (wide ? POS_W'(2) : POS_W'(4));

  // Consecutive positions fall into distinct banks, so each bank takes at
  // most one cell of the byte.
  always_comb begin
    logic [1:0]       j;
    logic [POS_W-1:0] pos_j;
    logic [3:0]       nib;
    logic [CELL_W-1:0] val;
    logic             active;
    for (int b = 0; b < BANKS; b++) begin
      j      = 2'(b) - position[1:0];
      pos_j  = position + {6'd0, j};
      nib    = slot_nib(data, wide, j);
      val    = wide ? {palette[2], nib} : {palette, nib[1:0]};
      active = !wide || (j < 2'd2);
      bank_wr[b].en   = go && active && ({1'b0, pos_j} < LINE_LIMIT) &&
                        ((nib != 4'd0) || kangaroo);
      bank_wr[b].addr = pos_j[POS_W-1:2];
      bank_wr[b].data = (nib != 4'd0) ? val : '0;
    end
  end

endmodule

/* rtl/core/slbe_read.sv */
// ----------------------------------------------------------------------------
// slbe_read
// Formats a stored cell into the palette offset of one output pixel.
// ----------------------------------------------------------------------------
module slbe_read
  import slbe_pkg::*;
(
  input  logic [CELL_W-1:0] entry,
  input  logic [1:0]        mode,
  input  logic              odd,
  input  logic              hit,
  output logic [CELL_W-1:0] color
);

  logic [CELL_W-1:0] v;

  always_comb begin
    case (mode)
      RM_WIDE:   v = entry;
      RM_HIRES2: v = odd ? {entry[4], 2'b00, entry[0], entry[2]}
                         : {entry[4], 2'b00, entry[1], entry[3]};
      RM_HIRES3: v = odd ? {entry[4:2], entry[0], 1'b0}
                         : {entry[4:1], 1'b0};
      default:   v = '0;
    endcase
  end

  // A pair of zero low bits selects the background.
  assign color = (hit && (v[1:0] != 2'b00)) ? v : '0;

endmodule

/* rtl/core/scanline_line_buffer_engine.sv */
// ----------------------------------------------------------------------------
// scanline_line_buffer_engine
// One scanline of 5-bit palette cells, filled object by object from graphic
// bytes and read back one output pixel at a time.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                       Payload
//  --------  ------------------------------  -------------------------------
//  input     start && !busy                  in_cmd .. in_pixel_x
//  result    out_valid (one cycle, no stall) out_color_index, out_pixel_valid
//  config    psel && penable && pwrite       paddr, pwdata, prdata
//
// Every command is a beat that yields exactly one result beat, registered
// through s1_valid_r and out_valid_r; a new command may follow in every cycle,
// so busy is never raised. The line is held in four cell banks (one per
// position mod 4), so a graphic byte writes its four or two cells together at
// acceptance, and a read uses the registered read port of the banks plus one
// format stage. Each cell has a valid flip-flop; reset and the clear command
// drop all of them at once, and a cell that is not valid reads as zero, so
// there is no clearing pass. Reset is synchronous and active low. The receiver
// cannot stall, so nothing ever waits inside the block.
//
module scanline_line_buffer_engine
  import slbe_pkg::*;
#(
  parameter int LINE_CELLS = LINE_CELLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_start_position,
  input  logic [2:0]  in_palette_number,
  input  logic        in_wide_mode,
  input  logic        in_update_wide_mode,
  input  logic [7:0]  in_graphic_byte,
  input  logic [15:0] in_source_address,
  input  logic        in_holey_eight,
  input  logic        in_holey_sixteen,
  input  logic [8:0]  in_pixel_x,

  output logic        out_valid,
  output logic [4:0]  out_color_index,
  output logic        out_pixel_valid,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Each bank holds every fourth cell of the line.
  localparam int BANK_DEPTH = (LINE_CELLS + BANKS - 1) / BANKS;
  localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int IW         = $clog2(LINE_CELLS);
  localparam logic [POS_W-1:0] LAST_CELL = POS_W'(LINE_CELLS - 1);

  // Configuration registers.
  logic       kangaroo_r;
  logic [1:0] read_mode_r;
  logic       cfg_wr;

  // Object state.
  logic [POS_W-1:0] write_position_r, write_position_nxt;
  logic [2:0]       current_palette_r, current_palette_nxt;
  logic             current_wide_r, current_wide_nxt;

  // Cell valid flags.
  logic [LINE_CELLS-1:0] cell_valid_r, cell_valid_nxt;

  // Read stage registers.
  logic                  s1_valid_r;
  logic                  s1_read_r;
  logic                  s1_hit_r;
  logic [1:0]            s1_bank_r;
  logic                  s1_odd_r;
  logic [1:0]            s1_mode_r;

  // Result registers.
  logic              out_valid_r;
  logic [CELL_W-1:0] out_color_r;
  logic              out_pv_r;

  logic                 accept;
  cmd_t                 cmd;
  logic                 is_read;
  logic [POS_W-1:0]     rd_idx;
  logic                 rd_in_line;
  logic [BAW-1:0]       rd_addr;
  logic [POS_W-1:0]     pos_next;
  bank_wr_t [BANKS-1:0] bank_wr;
  logic [CELL_W-1:0]    bank_rdata [BANKS];
  logic [CELL_W-1:0]    color;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;
  assign cmd    = cmd_t'(in_cmd);

  // --------------------------------------------------------------------------
  // Configuration port. Only bit 2 of the address picks the register.
  // --------------------------------------------------------------------------
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kangaroo_r  <= 1'b0;
      read_mode_r <= RM_WIDE;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_KANGAROO) begin
        kangaroo_r <= pwdata[0];
      end else begin
        read_mode_r <= pwdata[1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_READ_MODE) ? {30'd0, read_mode_r}
                                              : {31'd0, kangaroo_r};

  // --------------------------------------------------------------------------
  // Write path: a graphic byte is steered into the banks at acceptance.
  // --------------------------------------------------------------------------
  slbe_write #(
    .LINE_CELLS(LINE_CELLS)
  ) u_write (
    .go             (accept && (cmd == CMD_GRAPHIC)),
    .position       (write_position_r),
    .palette        (current_palette_r),
    .wide           (current_wide_r),
    .kangaroo       (kangaroo_r),
    .graphic_byte   (in_graphic_byte),
    .source_address (in_source_address),
    .holey_eight    (in_holey_eight),
    .holey_sixteen  (in_holey_sixteen),
    .bank_wr        (bank_wr),
    .position_next  (pos_next)
  );

  always_comb begin
    write_position_nxt  = write_position_r;
    current_palette_nxt = current_palette_r;
    current_wide_nxt    = current_wide_r;
    if (accept) begin
      case (cmd)
        CMD_OBJECT: begin
          write_position_nxt  = in_start_position;
          current_palette_nxt = in_palette_number;
          if (in_update_wide_mode) begin
            current_wide_nxt = in_wide_mode;
          end
        end
        CMD_GRAPHIC: begin
          write_position_nxt = pos_next;
        end
        default: begin
        end
      endcase
    end
  end

  // A clear drops every flag; a written cell becomes valid, zero or not.
  always_comb begin
    cell_valid_nxt = cell_valid_r;
    if (accept && (cmd == CMD_CLEAR)) begin
      cell_valid_nxt = '0;
    end else begin
      for (int b = 0; b < BANKS; b++) begin
        if (bank_wr[b].en) begin
          cell_valid_nxt[IW'({bank_wr[b].addr, 2'(b)})] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_position_r  <= '0;
      current_palette_r <= '0;
      current_wide_r    <= 1'b0;
      cell_valid_r      <= '0;
    end else begin
      write_position_r  <= write_position_nxt;
      current_palette_r <= current_palette_nxt;
      current_wide_r    <= current_wide_nxt;
      cell_valid_r      <= cell_valid_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Read path: all banks read the row of the pixel's cell, then one is picked.
  // --------------------------------------------------------------------------
  assign is_read    = (cmd == CMD_READ);
  assign rd_idx     = in_pixel_x[8:1];
  assign rd_in_line = (rd_idx <= LAST_CELL);
  assign rd_addr    = rd_in_line ? BAW'(rd_idx[POS_W-1:2]) : '0;

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    slbe_ram #(
      .WIDTH(CELL_W),
      .DEPTH(BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (bank_wr[b].en),
      .waddr (BAW'(bank_wr[b].addr)),
      .wdata (bank_wr[b].data),
      .raddr (rd_addr),
      .rdata (bank_rdata[b])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_read_r  <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      s1_read_r  <= accept && is_read && (read_mode_r != RM_NONE);
    end
    // A column past the line reads as background.
    s1_hit_r  <= rd_in_line && cell_valid_r[IW'(rd_idx)];
    s1_bank_r <= rd_idx[1:0];
    s1_odd_r  <= in_pixel_x[0];
    s1_mode_r <= read_mode_r;
  end

  slbe_read u_read (
    .entry (bank_rdata[s1_bank_r]),
    .mode  (s1_mode_r),
    .odd   (s1_odd_r),
    .hit   (s1_read_r && s1_hit_r),
    .color (color)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
    out_color_r <= color;
    out_pv_r    <= s1_read_r;
  end

  assign out_valid       = out_valid_r;
  assign out_color_index = out_color_r;
  assign out_pixel_valid = out_pv_r;

endmodule

/* bench/scanline_line_buffer_engine_test.sv */
// ----------------------------------------------------------------------------
// scanline_line_buffer_engine_test
// Self-checking bench for the scanline line buffer engine. Command beats are
// driven on the input channel while a scoreboard keeps its own copy of the
// line, the write position, the palette and the write mode, predicts the
// pixel beat of every command and compares it with what the block returns.
// ----------------------------------------------------------------------------

class line_scoreboard;

  localparam int CELLS = slbe_pkg::LINE_CELLS_DEF;

  typedef struct packed {
    logic [4:0] color_index;
    logic       pixel_valid;
  } pixel_beat_t;

  // Predicted copy of the block state and its two registers.
  logic [4:0]  cells [CELLS];
  logic [7:0]  write_pos;
  logic [2:0]  palette;
  logic        wide;
  logic        kangaroo;
  logic [1:0]  read_mode;

  pixel_beat_t expected_pixels [$];

  int mismatches;
  int pixels_checked;
  int cmd_count [4];

  function new();
    foreach (cells[i]) cells[i] = '0;
    write_pos = '0;
    palette   = '0;
    wide      = 1'b0;
    kangaroo  = 1'b0;
    read_mode = slbe_pkg::RM_WIDE;
    mismatches = 0;
    pixels_checked = 0;
    foreach (cmd_count[i]) cmd_count[i] = 0;
  endfunction

  task report(string what);
    $display("MISMATCH: %s", what);
    mismatches++;
  endtask

  function void set_register(logic idx, logic [31:0] value);
    if (idx == slbe_pkg::REG_KANGAROO) kangaroo = value[0];
    else read_mode = value[1:0];
  endfunction

  // A zero nibble only clears the entry when kangaroo mode is on.
  function void paint_cell(logic [3:0] nib, logic [4:0] value);
    if (write_pos < CELLS) begin
      if (nib != 4'd0) cells[write_pos] = value;
      else if (kangaroo) cells[write_pos] = 5'd0;
    end
    write_pos = write_pos + 8'd1;
  endfunction

  function void paint_byte(logic [7:0] gbyte, logic holey);
    logic [7:0] d;
    logic [3:0] first;
    logic [3:0] second;
    d = holey ? 8'd0 : gbyte;
    if (wide) begin
      first  = {d[3:2], d[7:6]};
      second = {d[1:0], d[5:4]};
      paint_cell(first, {palette[2], first});
      paint_cell(second, {palette[2], second});
    end else begin
      for (int k = 3; k >= 0; k--) paint_cell({2'b00, d[2*k +: 2]}, {palette, d[2*k +: 2]});
    end
  endfunction

  function logic [4:0] format_pixel(logic [8:0] x);
    logic [4:0] c;
    logic [4:0] v;
    if ((x >> 1) >= CELLS) return 5'd0;
    c = cells[x >> 1];
    case (read_mode)
      slbe_pkg::RM_WIDE:   v = c;
      slbe_pkg::RM_HIRES2: v = x[0] ? {c[4], 2'b00, c[0], c[2]} : {c[4], 2'b00, c[1], c[3]};
      default:             v = x[0] ? {c[4:2], c[0], 1'b0} : {c[4:1], 1'b0};
    endcase
    return (v[1:0] == 2'b00) ? 5'd0 : v;
  endfunction

  // Notes one accepted command beat and queues the pixel beat it must cause.
  function void take_command(slbe_pkg::cmd_t cmd, logic [7:0] pos, logic [2:0] pal,
                             logic wide_in, logic update_wide, logic [7:0] gbyte,
                             logic [15:0] addr, logic h8, logic h16, logic [8:0] x);
    pixel_beat_t beat;
    logic holey;
    beat = '0;
    cmd_count[cmd]++;
    case (cmd)
      slbe_pkg::CMD_CLEAR: foreach (cells[i]) cells[i] = 5'd0;
      slbe_pkg::CMD_OBJECT: begin
        write_pos = pos;
        palette   = pal;
        if (update_wide) wide = wide_in;
      end
      slbe_pkg::CMD_GRAPHIC: begin
        holey = addr[15] && ((h16 && addr[12]) || (h8 && addr[11]));
        paint_byte(gbyte, holey);
      end
      default: begin
        if (read_mode != slbe_pkg::RM_NONE) begin
          beat.color_index = format_pixel(x);
          beat.pixel_valid = 1'b1;
        end
      end
    endcase
    expected_pixels.push_back(beat);
  endfunction

  task check_pixel(logic [4:0] color_index, logic pixel_valid);
    pixel_beat_t want;
    if (expected_pixels.size() == 0) begin
      report($sformatf("pixel beat with nothing expected (color %0d valid %0b)",
                       color_index, pixel_valid));
    end else begin
      want = expected_pixels.pop_front();
      pixels_checked++;
      if (color_index !== want.color_index)
        report($sformatf("color_index %0d, expected %0d", color_index, want.color_index));
      if (pixel_valid !== want.pixel_valid)
        report($sformatf("pixel_valid %0b, expected %0b", pixel_valid, want.pixel_valid));
    end
  endtask

endclass

module scanline_line_buffer_engine_test;

  timeunit 1ns;
  timeprecision 1ps;

  import slbe_pkg::*;

  // Generous ceiling: about 450 beats with random sender gaps, a few dozen
  // register accesses and the drains stay far below it.
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_BEATS  = 400;
  localparam int CALM_TAIL     = 60;
  localparam int SEGMENTS      = 6;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_cmd;
  logic [7:0]  in_start_position;
  logic [2:0]  in_palette_number;
  logic        in_wide_mode;
  logic        in_update_wide_mode;
  logic [7:0]  in_graphic_byte;
  logic [15:0] in_source_address;
  logic        in_holey_eight;
  logic        in_holey_sixteen;
  logic [8:0]  in_pixel_x;
  logic        out_valid;
  logic [4:0]  out_color_index;
  logic        out_pixel_valid;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  line_scoreboard sb = new();

  int cycle_count = 0;
  int beats_sent  = 0;
  int settings_applied = 0;
  int idle_odds   = 0;   // 0 means no sender gaps; n means a gap about 1 in n beats

  scanline_line_buffer_engine DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_cmd              (in_cmd),
    .in_start_position   (in_start_position),
    .in_palette_number   (in_palette_number),
    .in_wide_mode        (in_wide_mode),
    .in_update_wide_mode (in_update_wide_mode),
    .in_graphic_byte     (in_graphic_byte),
    .in_source_address   (in_source_address),
    .in_holey_eight      (in_holey_eight),
    .in_holey_sixteen    (in_holey_sixteen),
    .in_pixel_x          (in_pixel_x),
    .out_valid           (out_valid),
    .out_color_index     (out_color_index),
    .out_pixel_valid     (out_pixel_valid),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #4 clk = ~clk;

  // The watchdog ends a hung run; a clean run finishes long before it.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Everything is sampled at the rising edge, before the block's own updates
  // land. The pixel beat is checked first, then a command beat taken at the
  // same edge is handed to the scoreboard, so a beat is never checked against
  // an expectation that its own command produced.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_pixel(out_color_index, out_pixel_valid);
      if (start && !busy)
        sb.take_command(cmd_t'(in_cmd), in_start_position, in_palette_number, in_wide_mode,
                        in_update_wide_mode, in_graphic_byte, in_source_address,
                        in_holey_eight, in_holey_sixteen, in_pixel_x);
    end
  end

  // Fields that a command ignores still carry random values, so the block
  // must prove that it really ignores them.
  task automatic scramble_fields();
    in_start_position   = 8'($urandom);
    in_palette_number   = 3'($urandom);
    in_wide_mode        = 1'($urandom);
    in_update_wide_mode = 1'($urandom);
    in_graphic_byte     = 8'($urandom);
    in_source_address   = 16'($urandom);
    in_holey_eight      = 1'($urandom);
    in_holey_sixteen    = 1'($urandom);
    in_pixel_x          = 9'($urandom_range(0, 319));
  endtask

  // Called at a falling edge with the fields set up. Start stays high on
  // return so that back-to-back beats keep it high without a dip.
  task automatic send_beat();
    int gap;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      gap = $urandom_range(1, 4);
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    do @(posedge clk); while (busy);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_clear();
    scramble_fields();
    in_cmd = CMD_CLEAR;
    send_beat();
  endtask

  task automatic send_object(logic [7:0] pos, logic [2:0] pal, logic wide, logic update);
    scramble_fields();
    in_cmd              = CMD_OBJECT;
    in_start_position   = pos;
    in_palette_number   = pal;
    in_wide_mode        = wide;
    in_update_wide_mode = update;
    send_beat();
  endtask

  task automatic send_graphic(logic [7:0] gbyte, logic [15:0] addr, logic h8, logic h16);
    scramble_fields();
    in_cmd            = CMD_GRAPHIC;
    in_graphic_byte   = gbyte;
    in_source_address = addr;
    in_holey_eight    = h8;
    in_holey_sixteen  = h16;
    send_beat();
  endtask

  task automatic send_read(logic [8:0] x);
    scramble_fields();
    in_cmd     = CMD_READ;
    in_pixel_x = x;
    send_beat();
  endtask

  // Lowers start and waits until every pixel beat has come back, then lets the
  // two-stage pipeline empty. Returns at a falling edge.
  task automatic wait_idle();
    start = 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // One write followed by a read-back of the same register. The block must
  // be idle when this is called.
  task automatic write_register(logic idx, logic [31:0] value);
    logic [31:0] got;
    logic [31:0] mask;
    mask    = (idx == REG_KANGAROO) ? 32'h1 : 32'h3;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {1'b0, idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if ((got & mask) != (value & mask))
      sb.report($sformatf("register %0d reads back %0h, wrote %0h", idx, got, value));
  endtask

  task automatic apply_setting(logic kangaroo, logic [1:0] mode);
    wait_idle();
    write_register(REG_KANGAROO, {31'd0, kangaroo});
    write_register(REG_READ_MODE, {30'd0, mode});
    settings_applied++;
  endtask

  // A well-formed object: header, a run of graphic bytes, then some reads.
  // Roughly one byte in six is forced onto a holey address; the others are random.
  task automatic send_object_run();
    int bytes;
    int reads;
    logic [15:0] addr;
    logic h8;
    logic h16;
    send_object(8'($urandom), 3'($urandom), 1'($urandom), 1'($urandom_range(0, 2) != 0));
    bytes = $urandom_range(1, 6);
    for (int i = 0; i < bytes; i++) begin
      addr = 16'($urandom);
      h8   = 1'($urandom);
      h16  = 1'($urandom);
      if ($urandom_range(0, 5) == 0) begin
        addr[15] = 1'b1;
        if (h16) addr[12] = 1'b1;
        else begin
          h8 = 1'b1;
          addr[11] = 1'b1;
        end
      end
      // Zero bytes are common enough to exercise the transparent path.
      send_graphic(($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom), addr, h8, h16);
    end
    reads = $urandom_range(1, 4);
    for (int i = 0; i < reads; i++) send_read(9'($urandom_range(0, 319)));
  endtask

  // Random mix of commands with random fields, including reads and clears
  // that land in the middle of an object.
  task automatic send_noise();
    scramble_fields();
    in_cmd = 2'($urandom);
    send_beat();
  endtask

  logic       seg_kangaroo [SEGMENTS] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  logic [1:0] seg_mode     [SEGMENTS] = '{RM_HIRES3, RM_NONE, RM_WIDE, RM_HIRES2,
                                          RM_HIRES2, RM_HIRES3};
  int         seg_idle     [SEGMENTS] = '{3, 0, 4, 2, 3, 0};

  initial begin
    int seg_end;
    int pick;
    clk      = 1'b0;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_cmd   = CMD_CLEAR;
    scramble_fields();
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part under reset settings: transparent zero cells, wide-pixel
    // readout. An empty line reads as background first.
    idle_odds = 3;
    send_read(9'd0);
    send_object(8'd0, 3'd7, 1'b0, 1'b1);
    send_graphic(8'hFF, 16'h0000, 1'b0, 1'b0);
    // Low address with both flags set is never holey; zero cells stay put.
    send_graphic(8'h1B, 16'h1234, 1'b1, 1'b1);
    // Wide mode right at the end of the line, then past it.
    send_object(8'd156, 3'd5, 1'b1, 1'b1);
    send_graphic(8'hE4, 16'h8000, 1'b1, 1'b1);
    send_graphic(8'hFF, 16'h7FFF, 1'b1, 1'b1);
    send_graphic(8'hFF, 16'hFFFF, 1'b0, 1'b0);
    // Header that keeps the wide mode; the position wraps from 255 to 0.
    send_object(8'd255, 3'd3, 1'b0, 1'b0);
    send_graphic(8'h5A, 16'h8000, 1'b0, 1'b0);
    // Holey by the eight flag, by the sixteen flag, then flags off.
    send_object(8'd8, 3'd2, 1'b0, 1'b1);
    send_graphic(8'hFF, 16'h8800, 1'b1, 1'b0);
    send_graphic(8'hFF, 16'h9000, 1'b0, 1'b1);
    send_graphic(8'hFF, 16'h9800, 1'b0, 1'b0);
    send_read(9'd1);
    send_read(9'd9);
    send_read(9'd319);

    // Kangaroo mode: a holey byte now punches zeros into the line.
    apply_setting(1'b1, RM_HIRES2);
    send_object(8'd0, 3'd0, 1'b0, 1'b0);
    send_graphic(8'hFF, 16'hF800, 1'b1, 1'b1);
    send_read(9'd0);
    send_read(9'd10);
    send_read(9'd11);
    apply_setting(1'b1, RM_HIRES3);
    send_read(9'd10);
    send_read(9'd11);
    apply_setting(1'b0, RM_NONE);
    send_read(9'd16);
    send_clear();
    send_read(9'd0);

    // Random part in segments, each under its own register setting. The
    // last stretch runs with the sender at full rate.
    beats_sent = 0;
    for (int s = 0; s < SEGMENTS; s++) begin
      apply_setting(seg_kangaroo[s], seg_mode[s]);
      seg_end = (RANDOM_BEATS * (s + 1)) / SEGMENTS;
      while (beats_sent < seg_end) begin
        idle_odds = (beats_sent >= RANDOM_BEATS - CALM_TAIL) ? 0 : seg_idle[s];
        pick = $urandom_range(0, 99);
        if (pick < 4) send_clear();
        else if (pick < 14) send_noise();
        else send_object_run();
        // Halfway through the third segment, hold off until the line is quiet.
        if (s == 2 && beats_sent >= seg_end - RANDOM_BEATS / (2 * SEGMENTS)
            && beats_sent < seg_end - RANDOM_BEATS / (2 * SEGMENTS) + 4)
          wait_idle();
      end
    end

    // Let the pipeline empty, then keep watching for stray beats.
    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.expected_pixels.size() != 0)
      sb.report($sformatf("%0d pixel beats never arrived", sb.expected_pixels.size()));

    $display("Run covered %0d clears, %0d object headers, %0d graphic bytes, %0d reads;",
             sb.cmd_count[CMD_CLEAR], sb.cmd_count[CMD_OBJECT],
             sb.cmd_count[CMD_GRAPHIC], sb.cmd_count[CMD_READ]);
    $display("%0d pixel beats compared over %0d register settings, %0d mismatches.",
             sb.pixels_checked, settings_applied, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
